/* sv/assert_macros.svh */
// Assertion helpers shared by the checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");

// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");

`endif

/* sv/evrd_pkg.sv */
package evrd_pkg;

  localparam int WindowDefault = 8;

  localparam logic [23:0] DppReset   = 24'd65536;
  localparam logic [15:0] StartReset = 16'd1229;
  localparam logic [15:0] EndReset   = 16'd410;
  localparam logic [15:0] MinReset   = 16'd300;

  localparam logic [1:0] REG_DPP   = 2'd0;
  localparam logic [1:0] REG_START = 2'd1;
  localparam logic [1:0] REG_END   = 2'd2;
  localparam logic [1:0] REG_MIN   = 2'd3;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_CLEAR  = 1'b1;

  // Request to the shared serial divider.
  typedef struct packed {
    logic        start;
    logic [63:0] dividend;
    logic [35:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] quotient;
  } div_rsp_t;

endpackage

/* sv/evrd_div.sv */
// Restoring divider, one quotient bit per cycle.
module evrd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  evrd_pkg::div_req_t req,
  output evrd_pkg::div_rsp_t rsp
);
  import evrd_pkg::*;

  logic [63:0] quo_r, quo_nxt;
  logic [36:0] rem_r, rem_nxt;
  logic [35:0] dvs_r, dvs_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [36:0] trial;
  logic [36:0] shifted;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r[35:0], quo_r[63]};
    trial    = shifted - {1'b0, dvs_r};
    if (req.start) begin
      quo_nxt  = req.dividend;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      cnt_nxt  = 7'd64;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[36]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;
endmodule

/* sv/evrd_window.sv */
// Sample window memory, cleared slot by slot after reset and written as a ring.
module evrd_window #(
  parameter int Window = evrd_pkg::WindowDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        rd_en,
  input  logic        wr_en,
  input  logic [15:0] wr_data,
  output logic [15:0] rd_data,
  output logic        clearing
);
  localparam int AW = (Window > 1) ? $clog2(Window) : 1;

  logic [15:0]   mem [Window];
  logic [AW-1:0] slot_r;
  logic [AW-1:0] clr_r;
  logic          clearing_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r     <= '0;
      clr_r      <= '0;
      clearing_r <= 1'b1;
    end else if (clearing_r) begin
      if (clr_r == AW'(Window - 1)) begin
        clearing_r <= 1'b0;
      end else begin
        clr_r <= clr_r + AW'(1);
      end
    end else if (wr_en) begin
      slot_r <= (slot_r == AW'(Window - 1)) ? '0 : slot_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_r] <= '0;
    end else if (wr_en) begin
      mem[slot_r] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[slot_r];
    end
  end

  assign clearing = clearing_r;
endmodule

/* sv/encoder_velocity_rep_detector.sv */
// Channel | Direction | Handshake           | Payload
// in      | input     | in_valid/in_stall   | func, encoder_count, time_ms
// out     | output    | out_valid/out_stall | speeds, rep flags, totals, change
// cfg     | input     | cfg_we              | cfg_index, cfg_data
// A new item is taken only once the last is through. A velocity sample runs
// one 64-step serial division for the speed on the shared divider, and the
// window average is a division by WINDOW outside it. A sample that ends a
// rep runs a division for the rep mean and, if the best mean is not zero,
// one for the percent change. A sample with no elapsed time or no distance
// per pulse skips the speed division. A clear item goes from S_IDLE to S_OUT.
// After reset the window memory is cleared before the first item is taken.
// The result sits in an output register; a stalled result holds the block.
module encoder_velocity_rep_detector #(
  parameter int WINDOW = evrd_pkg::WindowDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_func,
  input  logic signed [31:0] in_encoder_count,
  input  logic [31:0] in_time_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_raw_speed,
  output logic [15:0] out_smooth_speed,
  output logic        out_in_rep,
  output logic        out_rep_done,
  output logic [15:0] out_rep_total,
  output logic [15:0] out_mean_speed,
  output logic [15:0] out_peak_speed,
  output logic signed [23:0] out_speed_change,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);
  import evrd_pkg::*;

  localparam int TW = 16 + $clog2(WINDOW + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SPD, S_WIN, S_MEAN, S_CHG, S_OUT
  } state_t;

  state_t state_r;
  logic [23:0] dpp_r;
  logic [15:0] start_r, end_r, min_r;
  logic [31:0] prev_count_r, prev_time_r, now_r, start_stamp_r, rep_sum_r;
  logic [TW-1:0] total_r;
  logic        active_r;
  logic [15:0] peak_r, samples_r, counter_r, best_r, last_mean_r, raw_r;
  logic [23:0] change_r;
  logic        done_r, ovalid_r;
  logic [31:0] mag_r, dt_r;
  logic [15:0] smooth_r;

  div_req_t    dreq;
  div_rsp_t    drsp;
  logic        win_rd, win_wr, clearing;
  logic [15:0] old_val;

  evrd_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
  evrd_window #(.Window(WINDOW)) u_win (
    .clk(clk), .rst_n(rst_n), .rd_en(win_rd), .wr_en(win_wr),
    .wr_data(raw_r), .rd_data(old_val), .clearing(clearing));

  assign in_stall = (state_r != S_IDLE) || clearing || (ovalid_r && out_stall);
  wire accept = in_valid && !in_stall;

  // Combinational helpers for the sample path.
  logic [31:0] diff;
  logic [TW-1:0] new_total;
  logic [15:0] smooth_c;
  logic [15:0] mean_c;
  always_comb begin
    diff      = in_encoder_count - prev_count_r;
    new_total = total_r - TW'(old_val) + TW'(raw_r);
    smooth_c  = 16'(new_total / WINDOW);
    mean_c    = (drsp.quotient[63:16] != '0) ? 16'hFFFF : drsp.quotient[15:0];
  end

  logic [15:0] ctr_inc;
  assign ctr_inc = (counter_r == 16'hFFFF) ? counter_r : counter_r + 16'd1;

  logic        chg_neg;

  always_ff @(posedge clk) begin
    logic go;
    go = 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      dpp_r <= DppReset; start_r <= StartReset; end_r <= EndReset; min_r <= MinReset;
      prev_count_r <= '0; prev_time_r <= '0; total_r <= '0; active_r <= 1'b0;
      start_stamp_r <= '0; peak_r <= '0; rep_sum_r <= '0; samples_r <= '0;
      counter_r <= '0; best_r <= '0; last_mean_r <= '0; change_r <= '0;
      ovalid_r <= 1'b0; done_r <= 1'b0; raw_r <= '0; smooth_r <= '0;
      chg_neg <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DPP:   dpp_r   <= cfg_data;
          REG_START: start_r <= cfg_data[15:0];
          REG_END:   end_r   <= cfg_data[15:0];
          REG_MIN:   min_r   <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (ovalid_r && !out_stall) ovalid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (accept) begin
          done_r <= 1'b0;
          raw_r  <= '0;
          if (in_func == FUNC_CLEAR) begin
            counter_r <= '0;
            smooth_r  <= 16'(total_r / WINDOW);
            state_r   <= S_OUT;
          end else begin
            mag_r <= diff[31] ? (~diff + 32'd1) : diff;
            dt_r  <= in_time_ms - prev_time_r;
            now_r <= in_time_ms;
            prev_count_r <= in_encoder_count;
            prev_time_r  <= in_time_ms;
            state_r <= S_RD;
          end
        end
        S_RD: begin
          if (dt_r == '0 || dpp_r == '0) begin
            raw_r   <= '0;
            state_r <= S_WIN;
          end else begin
            dreq.dividend <= 64'(mag_r) * 64'(dpp_r);
            dreq.divisor  <= {dt_r, 4'b0};
            go = 1'b1;
            state_r <= S_SPD;
          end
        end
        S_SPD: if (drsp.done) begin
          raw_r <= (drsp.quotient[63:16] != '0) ? 16'hFFFF : drsp.quotient[15:0];
          state_r <= S_WIN;
        end
        S_WIN: begin
          total_r  <= new_total;
          smooth_r <= smooth_c;
          if (!active_r) begin
            if (smooth_c > start_r) begin
              active_r <= 1'b1; start_stamp_r <= now_r; peak_r <= smooth_c;
              rep_sum_r <= 32'(smooth_c); samples_r <= 16'd1;
            end
            state_r <= S_OUT;
          end else begin
            logic [31:0] s_n; logic [15:0] c_n;
            s_n = rep_sum_r; c_n = samples_r;
            if (samples_r != 16'hFFFF) begin
              s_n = rep_sum_r + 32'(smooth_c); c_n = samples_r + 16'd1;
            end
            rep_sum_r <= s_n; samples_r <= c_n;
            if (smooth_c > peak_r) peak_r <= smooth_c;
            if (smooth_c < end_r && (now_r - start_stamp_r) > 32'(min_r)) begin
              dreq.dividend <= 64'(s_n);
              dreq.divisor  <= 36'(c_n);
              go = 1'b1;
              active_r <= 1'b0;
              done_r   <= 1'b1;
              counter_r <= ctr_inc;
              state_r  <= S_MEAN;
            end else begin
              state_r <= S_OUT;
            end
          end
        end
        S_MEAN: if (drsp.done) begin
          logic [15:0] b;
          b = (counter_r == 16'd1) ? mean_c : best_r;
          last_mean_r <= mean_c;
          best_r <= b;
          if (b != '0) begin
            chg_neg <= (mean_c < b);
            dreq.dividend <= 64'((mean_c < b) ? (b - mean_c) : (mean_c - b)) * 64'd10000;
            dreq.divisor  <= 36'(b);
            go = 1'b1;
            state_r <= S_CHG;
          end else begin
            state_r <= S_OUT;
          end
        end
        S_CHG: if (drsp.done) begin
          if (chg_neg) begin
            change_r <= (drsp.quotient > 64'd8388608) ? 24'h800000 :
                        24'(~drsp.quotient + 64'd1);
          end else begin
            change_r <= (drsp.quotient > 64'd8388607) ? 24'h7FFFFF : 24'(drsp.quotient);
          end
          if (last_mean_r > best_r) best_r <= last_mean_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          ovalid_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
    dreq.start <= go;
  end

  assign win_rd = (state_r == S_RD);
  assign win_wr = (state_r == S_WIN);

  assign out_valid        = ovalid_r;
  assign out_raw_speed    = raw_r;
  assign out_smooth_speed = smooth_r;
  assign out_in_rep       = active_r;
  assign out_rep_done     = done_r;
  assign out_rep_total    = counter_r;
  assign out_mean_speed   = last_mean_r;
  assign out_peak_speed   = peak_r;
  assign out_speed_change = change_r;
endmodule

/* sv/evrd_checker.sv */
module evrd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_rep_done,
  input logic out_in_rep
);
  `include "assert_macros.svh"

  `CHK_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `CHK_IMPLY(a_done_ends, clk, rst_n, out_valid && out_rep_done, !out_in_rep)
  `CHK_IMPLY(a_busy_out, clk, rst_n, out_valid && out_stall, in_stall)
  `CHK_NEXT(a_take_busy, clk, rst_n, in_valid && !in_stall, in_stall)
endmodule

bind encoder_velocity_rep_detector evrd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall),
  .out_rep_done(out_rep_done), .out_in_rep(out_in_rep));

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import evrd_pkg::*;

  // One result of the block, laid out the way the output ports present it.
  typedef struct packed {
    logic [15:0]        raw_speed;
    logic [15:0]        smooth_speed;
    logic               in_rep;
    logic               rep_done;
    logic [15:0]        rep_total;
    logic [15:0]        mean_speed;
    logic [15:0]        peak_speed;
    logic signed [23:0] speed_change;
  } rep_result_t;

  // Tracks the speed and rep state of the detector and holds the results
  // that accepted items are still owed.
  class rep_scoreboard;
    rep_result_t owed[$];
    int          errors;

    logic [23:0] dpp;
    logic [15:0] start_thr, end_thr, min_ms;

    logic [31:0] last_count, last_time, rep_start_time, rep_total_sum;
    logic [15:0] window_mem [8];
    logic [2:0]  slot;
    logic [31:0] window_sum;
    logic        active;
    logic [15:0] peak, rep_len, reps, best, last_mean;
    logic signed [23:0] last_change;

    function new();
      dpp = DppReset;
      start_thr = StartReset;
      end_thr = EndReset;
      min_ms = MinReset;
      last_count = '0;
      last_time = '0;
      rep_start_time = '0;
      rep_total_sum = '0;
      foreach (window_mem[i]) window_mem[i] = '0;
      slot = '0;
      window_sum = '0;
      active = 1'b0;
      peak = '0;
      rep_len = '0;
      reps = '0;
      best = '0;
      last_mean = '0;
      last_change = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [23:0] data);
      case (idx)
        REG_DPP:   dpp = data;
        REG_START: start_thr = data[15:0];
        REG_END:   end_thr = data[15:0];
        REG_MIN:   min_ms = data[15:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Closes the current rep: counts it, takes its mean and compares that
    // mean with the best one of the set.
    function void close_rep();
      longint unsigned mean;
      longint          pct;
      mean = (rep_len != 0) ? rep_total_sum / rep_len : 0;
      if (mean > 65535) mean = 65535;
      active = 1'b0;
      if (reps != 16'hFFFF) reps++;
      last_mean = mean[15:0];
      if (reps == 16'd1) best = mean[15:0];
      if (best != 0) begin
        pct = (longint'(mean) - longint'(best)) * 10000 / longint'(best);
        if (pct > 8388607) pct = 8388607;
        if (pct < -8388608) pct = -8388608;
        last_change = pct[23:0];
        if (mean > best) best = mean[15:0];
      end
    endfunction

    function void note_input(logic func, logic [31:0] count, logic [31:0] stamp);
      rep_result_t     r;
      logic [31:0]     diff, dt;
      longint unsigned mag, q;
      logic [15:0]     raw, avg;
      logic            done;
      raw = '0;
      done = 1'b0;
      if (func == FUNC_CLEAR) begin
        reps = '0;
        avg = 16'(window_sum / 8);
      end else begin
        diff = count - last_count;
        dt = stamp - last_time;
        mag = diff[31] ? longint'(32'(-diff)) : longint'(diff);
        last_count = count;
        last_time = stamp;
        if (dt != 0) begin
          q = mag * dpp / (longint'(dt) * 16);
          raw = (q > 65535) ? 16'hFFFF : q[15:0];
        end
        window_sum = window_sum - window_mem[slot] + raw;
        window_mem[slot] = raw;
        slot++;
        avg = 16'(window_sum / 8);
        if (!active) begin
          if (avg > start_thr) begin
            active = 1'b1;
            rep_start_time = stamp;
            peak = avg;
            rep_total_sum = 32'(avg);
            rep_len = 16'd1;
          end
        end else begin
          // Very long reps freeze the mean after the first 65535 samples.
          if (rep_len != 16'hFFFF) begin
            rep_total_sum = rep_total_sum + 32'(avg);
            rep_len++;
          end
          if (avg > peak) peak = avg;
          if (avg < end_thr && (stamp - rep_start_time) > min_ms) begin
            close_rep();
            done = 1'b1;
          end
        end
      end
      r.raw_speed = raw;
      r.smooth_speed = avg;
      r.in_rep = active;
      r.rep_done = done;
      r.rep_total = reps;
      r.mean_speed = last_mean;
      r.peak_speed = peak;
      r.speed_change = last_change;
      owed.push_back(r);
    endfunction

    function void compare(string field, longint e, longint a);
      if (e != a) begin
        $display("%0t mismatch %s: expected %0d actual %0d", $time, field, e, a);
        errors++;
      end
    endfunction

    function void check_result(rep_result_t a);
      rep_result_t e;
      if (owed.size() == 0) begin
        $display("%0t unexpected result: expected none actual %p", $time, a);
        errors++;
        return;
      end
      e = owed.pop_front();
      compare("raw_speed", e.raw_speed, a.raw_speed);
      compare("smooth_speed", e.smooth_speed, a.smooth_speed);
      compare("in_rep", e.in_rep, a.in_rep);
      compare("rep_done", e.rep_done, a.rep_done);
      compare("rep_total", e.rep_total, a.rep_total);
      compare("mean_speed", e.mean_speed, a.mean_speed);
      compare("peak_speed", e.peak_speed, a.peak_speed);
      compare("speed_change", e.speed_change, a.speed_change);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid, in_stall, in_func;
  logic signed [31:0] in_encoder_count;
  logic [31:0] in_time_ms;
  logic        out_valid, out_stall;
  logic [15:0] out_raw_speed, out_smooth_speed, out_rep_total;
  logic [15:0] out_mean_speed, out_peak_speed;
  logic        out_in_rep, out_rep_done;
  logic signed [23:0] out_speed_change;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [23:0] cfg_data;

  encoder_velocity_rep_detector u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_func(in_func),
    .in_encoder_count(in_encoder_count), .in_time_ms(in_time_ms),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_raw_speed(out_raw_speed), .out_smooth_speed(out_smooth_speed),
    .out_in_rep(out_in_rep), .out_rep_done(out_rep_done),
    .out_rep_total(out_rep_total), .out_mean_speed(out_mean_speed),
    .out_peak_speed(out_peak_speed), .out_speed_change(out_speed_change),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rep_scoreboard sb = new();

  // Idle rates in percent for each side, changed as the run moves on.
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  // Set by the stimulus to ask the receiver for one long hold-off.
  bit hold_req = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  // Motion state that the well-formed rep sequences continue from.
  logic [31:0] pos;
  logic [31:0] clock_ms;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, or for one long stretch when asked. The
  // hold-off is counted here so that the sender keeps offering items while
  // the block backs up and stalls its input.
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = 400;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // Accepted items on either channel go to the scoreboard. Sampling at the
  // edge sees the values that held before it, since everything is driven
  // with nonblocking assignments.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_input(in_func, in_encoder_count, in_time_ms);
    end
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result('{out_raw_speed, out_smooth_speed, out_in_rep, out_rep_done,
                        out_rep_total, out_mean_speed, out_peak_speed,
                        out_speed_change});
    end
  end

  // Watchdog: no transfer for longer than any item and the long hold-off
  // take means the block has hung.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 20000) begin
      $display("tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one item and waits until the block takes it. Idle gaps drop
  // valid first, so valid is never lowered and raised in the same step.
  task automatic send_item(logic func, logic [31:0] count, logic [31:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_encoder_count <= count;
    in_time_ms <= stamp;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  // A velocity sample that moves the encoder by delta over dt milliseconds.
  task automatic move(int delta, int dt);
    pos = pos + delta;
    clock_ms = clock_ms + dt;
    send_item(FUNC_SAMPLE, pos, clock_ms);
  endtask

  // One lift: speed ramps up and back down, then the bar rests long enough
  // for the moving average to settle to zero.
  task automatic lift();
    int steps, dt, top, dir, dc;
    steps = $urandom_range(3, 25);
    dt = $urandom_range(1, 9);
    top = $urandom_range(1, 60);
    dir = $urandom_range(1) ? 1 : -1;
    for (int i = 0; i <= 2 * steps; i++) begin
      dc = top * ((i < steps) ? i : 2 * steps - i) / steps;
      move(dir * dc, dt);
    end
    for (int i = 0; i < 8; i++) move(0, $urandom_range(1, 60));
  endtask

  // Registers change only with the block idle: nothing offered and every
  // owed result returned.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_all(logic [23:0] dpp, logic [15:0] st, logic [15:0] en,
                         logic [15:0] mn);
    drain();
    write_reg(REG_DPP, dpp);
    write_reg(REG_START, {8'd0, st});
    write_reg(REG_END, {8'd0, en});
    write_reg(REG_MIN, {8'd0, mn});
  endtask

  // Random part of one configuration phase: mostly well-formed lifts, some
  // arbitrary samples with every bit free, and the odd clear.
  task automatic random_phase(int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      if (items_sent >= 200) begin
        send_idle_pct = 78;
        recv_idle_pct = 20;
      end
      if (items_sent >= 380) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      pick = $urandom_range(99);
      if (pick < 75) begin
        lift();
      end else if (pick < 90) begin
        pos = $urandom;
        clock_ms = $urandom;
        send_item(FUNC_SAMPLE, pos, clock_ms);
      end else begin
        send_item(FUNC_CLEAR, $urandom, $urandom);
      end
    end
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_func <= FUNC_SAMPLE;
    in_encoder_count <= '0;
    in_time_ms <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_DPP;
    cfg_data <= '0;
    pos = '0;
    clock_ms = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset settings. No elapsed time gives no speed,
    // and the extreme counts and differences saturate the raw speed.
    send_item(FUNC_SAMPLE, 32'd0, 32'd0);
    send_item(FUNC_SAMPLE, 32'h7FFF_FFFF, 32'd1);
    send_item(FUNC_SAMPLE, 32'h8000_0000, 32'd2);
    send_item(FUNC_SAMPLE, 32'hFFFF_FFFF, 32'd3);
    // The timestamp wraps past its top value.
    send_item(FUNC_SAMPLE, 32'hFFFF_FFF0, 32'hFFFF_FFFF);
    send_item(FUNC_SAMPLE, 32'hFFFF_FFF6, 32'd4);
    send_item(FUNC_SAMPLE, 32'hFFFF_FFF6, 32'd4);
    // A clear while the window still holds speed.
    send_item(FUNC_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    pos = 32'hFFFF_FFF6;
    clock_ms = 32'd4;
    for (int i = 0; i < 8; i++) move(0, 100);
    lift();
    send_item(FUNC_CLEAR, 32'd0, 32'd0);

    // A zero distance per pulse gives no speed at all.
    set_all(24'd0, 16'd0, 16'd0, 16'd0);
    move(1000, 1);
    move(-5, 3);

    // The sender withdraws and waits for every owed result before going on.
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    send_idle_pct = 20;
    recv_idle_pct = 78;
    set_all(DppReset, StartReset, EndReset, MinReset);
    hold_req = 1;
    random_phase(150);

    // Highest distance, reps start on any motion and end at once.
    set_all(24'hFF_FFFF, 16'd0, 16'hFFFF, 16'd0);
    random_phase(280);

    // Lowest distance and thresholds that keep a rep from ever starting or ending.
    set_all(24'd1, 16'hFFFF, 16'd0, 16'hFFFF);
    random_phase(400);

    set_all(24'd131072, 16'd3000, 16'd800, 16'd100);
    random_phase(550);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
